/* design/ncfr_pkg.sv */
`default_nettype none

package ncfr_pkg;

    // raw frame capacity: start byte plus code bytes kept
    localparam int RAW_CAPACITY = 64;
    localparam int STORED_W     = $clog2(RAW_CAPACITY + 1);
    localparam int DCOUNT_W     = 7;

    // result queue sizing
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    // crc-8, reflected form
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_START_CODE    = 2'd0;
    localparam logic [1:0] CFG_END_CODE      = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0]  START_CODE_RST    = 8'h02;
    localparam logic [7:0]  END_CODE_RST      = 8'h03;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CRC   = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_FRAME_ERR = 3'd4
    } t_status;

    typedef struct packed {
        logic                is_end;
        logic [7:0]          data_byte;
        t_status             status;
        logic [DCOUNT_W-1:0] payload_length;
        logic [7:0]          crc_received;
        logic [7:0]          crc_computed;
    } t_result;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

    // one byte through the reflected crc-8, lsb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = data;
        for (int k = 0; k < 8; k++) begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* design/ncfr_result_fifo.sv */
`default_nettype none

module ncfr_result_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire ncfr_pkg::t_push   i_push,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire                    i_ready,
    output ncfr_pkg::t_result      o_result
);

    ncfr_pkg::t_result                    r_mem [ncfr_pkg::FIFO_DEPTH];
    logic [ncfr_pkg::FIFO_PTR_W-1:0]      r_wr_ptr;
    logic [ncfr_pkg::FIFO_PTR_W-1:0]      r_rd_ptr;
    logic [ncfr_pkg::FIFO_CNT_W-1:0]      r_count;
    logic [ncfr_pkg::FIFO_CNT_W-1:0]      n_count;
    logic [ncfr_pkg::FIFO_PTR_W-1:0]      wr_ptr_next;
    logic                                 pop;

    // room for a full pair of results
    assign o_room      = (r_count <= ncfr_pkg::FIFO_CNT_W'(ncfr_pkg::FIFO_DEPTH - 2));
    assign o_valid     = (r_count != '0);
    assign o_result    = r_mem[r_rd_ptr];
    assign pop         = o_valid & i_ready;
    assign wr_ptr_next = r_wr_ptr + ncfr_pkg::FIFO_PTR_W'(1);

    always_comb begin
        n_count = r_count + ncfr_pkg::FIFO_CNT_W'(i_push.cnt)
                  - ncfr_pkg::FIFO_CNT_W'(pop);
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + ncfr_pkg::FIFO_PTR_W'(i_push.cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + ncfr_pkg::FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

/* design/nibble_complement_frame_receiver.sv */
// results: an accepted item puts its results in the output queue at its accepting edge,
//   so a result can be taken in the cycle after its request is accepted
// throughput: one request per cycle; an end byte after an odd nibble count gives
//   two results, and ready stays high while the 4-entry result queue has room for two
// reset: synchronous, active low; clears the frame state and the result queue and
//   loads start_code 0x02, end_code 0x03, timeout_ticks 1000
`default_nettype none

module nibble_complement_frame_receiver (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_func,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_is_end,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_status,
    output logic [6:0]  o_payload_length,
    output logic [7:0]  o_crc_received,
    output logic [7:0]  o_crc_computed
);

    localparam int SW = ncfr_pkg::STORED_W;
    localparam int DW = ncfr_pkg::DCOUNT_W;

    // configuration
    logic [7:0]    r_start_code;
    logic [7:0]    r_end_code;
    logic [31:0]   r_timeout;

    // frame state
    logic          r_in_frame,      n_in_frame;
    logic          r_half_done,     n_half_done;
    logic [3:0]    r_held_nibble,   n_held_nibble;
    logic          r_pending_valid, n_pending_valid;
    logic [7:0]    r_pending_byte,  n_pending_byte;
    logic [7:0]    r_running_crc,   n_running_crc;
    logic [SW-1:0] r_stored_count,  n_stored_count;
    logic [DW-1:0] r_decoded_count, n_decoded_count;
    logic [31:0]   r_elapsed,       n_elapsed;

    logic              in_fire;
    logic              room;
    ncfr_pkg::t_push   push;
    ncfr_pkg::t_result q_result;
    ncfr_pkg::t_result data_res;
    ncfr_pkg::t_result stat_res;
    logic              data_emit;
    logic              stat_emit;
    logic              do_clear;

    logic [31:0]   elapsed_inc;
    logic [7:0]    code_byte;
    logic [7:0]    end_byte;
    logic          code_ok;
    logic          pv_after;
    logic [7:0]    pb_after;
    logic [7:0]    crc_after;
    logic [DW-1:0] dc_after;

    assign in_fire = i_valid & o_ready;
    assign o_ready = room;

    assign elapsed_inc = (r_elapsed != '1) ? (r_elapsed + 32'd1) : r_elapsed;
    assign code_ok     = (i_rx_byte[7:4] == ~i_rx_byte[3:0]);
    assign code_byte   = {r_held_nibble, i_rx_byte[7:4]};
    assign end_byte    = {r_held_nibble, r_end_code[7:4]};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= ncfr_pkg::START_CODE_RST;
            r_end_code   <= ncfr_pkg::END_CODE_RST;
            r_timeout    <= ncfr_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ncfr_pkg::CFG_START_CODE:    r_start_code <= i_cfg_data[7:0];
                ncfr_pkg::CFG_END_CODE:      r_end_code   <= i_cfg_data[7:0];
                ncfr_pkg::CFG_TIMEOUT_TICKS: r_timeout    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-request decode, crc and status
    always_comb begin
        n_in_frame      = r_in_frame;
        n_half_done     = r_half_done;
        n_held_nibble   = r_held_nibble;
        n_pending_valid = r_pending_valid;
        n_pending_byte  = r_pending_byte;
        n_running_crc   = r_running_crc;
        n_stored_count  = r_stored_count;
        n_decoded_count = r_decoded_count;
        n_elapsed       = r_elapsed;
        data_res        = '0;
        stat_res        = '0;
        data_emit       = 1'b0;
        stat_emit       = 1'b0;
        do_clear        = 1'b0;
        pv_after        = r_pending_valid;
        pb_after        = r_pending_byte;
        crc_after       = r_running_crc;
        dc_after        = r_decoded_count;

        if (in_fire) begin
            if (i_func) begin
                // millisecond tick
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= r_timeout) begin
                    stat_emit       = 1'b1;
                    stat_res.is_end = 1'b1;
                    stat_res.status = ncfr_pkg::ST_TIMEOUT;
                    do_clear        = 1'b1;
                end
            end else if (r_elapsed >= r_timeout) begin
                stat_emit       = 1'b1;
                stat_res.is_end = 1'b1;
                stat_res.status = ncfr_pkg::ST_TIMEOUT;
                do_clear        = 1'b1;
            end else if (r_stored_count >= SW'(ncfr_pkg::RAW_CAPACITY)) begin
                stat_emit       = 1'b1;
                stat_res.is_end = 1'b1;
                stat_res.status = ncfr_pkg::ST_OVERFLOW;
                do_clear        = 1'b1;
            end else if (i_rx_byte == r_start_code) begin
                // open or restart the frame
                n_in_frame      = 1'b1;
                n_half_done     = 1'b0;
                n_held_nibble   = '0;
                n_pending_valid = 1'b0;
                n_pending_byte  = '0;
                n_running_crc   = '0;
                n_stored_count  = SW'(1);
                n_decoded_count = '0;
                n_elapsed       = '0;
            end else if (i_rx_byte == r_end_code) begin
                // odd nibble count: finish the last byte from the end code
                if (r_in_frame && r_half_done) begin
                    if (r_pending_valid) begin
                        data_emit          = 1'b1;
                        data_res.data_byte = r_pending_byte;
                        crc_after = ncfr_pkg::crc8_step(r_running_crc, r_pending_byte);
                    end
                    pv_after = 1'b1;
                    pb_after = end_byte;
                    dc_after = r_decoded_count + DW'(1);
                end
                stat_emit       = 1'b1;
                stat_res.is_end = 1'b1;
                if (!r_in_frame || (dc_after == '0) || !pv_after) begin
                    stat_res.status = ncfr_pkg::ST_FRAME_ERR;
                end else begin
                    stat_res.status = (pb_after == crc_after) ? ncfr_pkg::ST_OK
                                                              : ncfr_pkg::ST_BAD_CRC;
                    stat_res.payload_length = dc_after - DW'(1);
                    stat_res.crc_received   = pb_after;
                    stat_res.crc_computed   = crc_after;
                end
                do_clear = 1'b1;
            end else if (r_in_frame && code_ok) begin
                // code byte adds one nibble
                n_stored_count = r_stored_count + SW'(1);
                if (!r_half_done) begin
                    n_held_nibble = i_rx_byte[7:4];
                    n_half_done   = 1'b1;
                end else begin
                    n_half_done = 1'b0;
                    if (r_pending_valid) begin
                        data_emit          = 1'b1;
                        data_res.data_byte = r_pending_byte;
                        n_running_crc = ncfr_pkg::crc8_step(r_running_crc, r_pending_byte);
                    end
                    n_pending_byte  = code_byte;
                    n_pending_valid = 1'b1;
                    n_decoded_count = r_decoded_count + DW'(1);
                end
            end
        end

        // end of run
        if (do_clear) begin
            n_in_frame      = 1'b0;
            n_half_done     = 1'b0;
            n_held_nibble   = '0;
            n_pending_valid = 1'b0;
            n_pending_byte  = '0;
            n_running_crc   = '0;
            n_stored_count  = '0;
            n_decoded_count = '0;
            n_elapsed       = '0;
        end
    end

    // order results into the queue, data before status
    always_comb begin
        push = '0;
        if (data_emit && stat_emit) begin
            push.cnt    = 2'd2;
            push.first  = data_res;
            push.second = stat_res;
        end else if (data_emit) begin
            push.cnt   = 2'd1;
            push.first = data_res;
        end else if (stat_emit) begin
            push.cnt   = 2'd1;
            push.first = stat_res;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame      <= 1'b0;
            r_half_done     <= 1'b0;
            r_held_nibble   <= '0;
            r_pending_valid <= 1'b0;
            r_pending_byte  <= '0;
            r_running_crc   <= '0;
            r_stored_count  <= '0;
            r_decoded_count <= '0;
            r_elapsed       <= '0;
        end else begin
            r_in_frame      <= n_in_frame;
            r_half_done     <= n_half_done;
            r_held_nibble   <= n_held_nibble;
            r_pending_valid <= n_pending_valid;
            r_pending_byte  <= n_pending_byte;
            r_running_crc   <= n_running_crc;
            r_stored_count  <= n_stored_count;
            r_decoded_count <= n_decoded_count;
            r_elapsed       <= n_elapsed;
        end
    end

    // result queue
    ncfr_result_fifo u_result_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (q_result)
    );

    assign o_is_end         = q_result.is_end;
    assign o_data_byte      = q_result.data_byte;
    assign o_status         = q_result.status;
    assign o_payload_length = q_result.payload_length;
    assign o_crc_received   = q_result.crc_received;
    assign o_crc_computed   = q_result.crc_computed;

    // a held nibble or pending byte only exists inside a frame
    a_half_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half_done |-> r_in_frame)
        else $error("held nibble outside a frame");

    a_pending_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending_valid |-> (r_in_frame && (r_decoded_count != '0)))
        else $error("pending byte outside a frame");

    // raw byte count never passes the capacity
    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored_count <= SW'(ncfr_pkg::RAW_CAPACITY))
        else $error("stored count beyond capacity");

    // a status result always ends the run
    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat_emit |=> (!r_in_frame && (r_elapsed == '0)))
        else $error("run state kept after status");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int RAND_REQUESTS   = 1700;
    localparam int RAND_PHASES     = 10;
    localparam int DRAIN_TAIL      = 3;
    localparam int END_TAIL        = 8;
    localparam int WATCHDOG_CYCLES = 2000;

    // index the block has no register behind
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [31:0] i_cfg_data  = 32'd0;
    logic        i_valid     = 1'b0;
    logic        i_func      = 1'b0;
    logic [7:0]  i_rx_byte   = 8'd0;
    logic        i_ready     = 1'b0;
    wire         o_ready;
    wire         o_valid;
    wire         o_is_end;
    wire  [7:0]  o_data_byte;
    wire  [2:0]  o_status;
    wire  [6:0]  o_payload_length;
    wire  [7:0]  o_crc_received;
    wire  [7:0]  o_crc_computed;

    nibble_complement_frame_receiver u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_is_end         (o_is_end),
        .o_data_byte      (o_data_byte),
        .o_status         (o_status),
        .o_payload_length (o_payload_length),
        .o_crc_received   (o_crc_received),
        .o_crc_computed   (o_crc_computed)
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // decoder copy: configuration
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_end;
    logic [31:0] cfg_timeout;

    // decoder copy: frame state
    logic        frame_open;
    logic        nibble_half;
    logic [3:0]  held_nib;
    logic        last_valid;
    logic [7:0]  last_byte;
    logic [7:0]  crc_acc;
    logic [7:0]  raw_count;
    logic [6:0]  byte_count;
    logic [31:0] tick_count;

    // decoded bytes and frame reports still to come out
    ncfr_pkg::t_result frame_out_q[$];

    typedef struct packed {
        logic              is_cfg;
        logic              func;
        logic [7:0]        rx_byte;
        logic [1:0]        cfg_index;
        logic [31:0]       cfg_value;
        logic              pinned;
        ncfr_pkg::t_result want;
    } t_stim_row;

    t_stim_row stim_rows[$];
    t_stim_row row;
    logic [7:0] frame_bytes[$];

    int  requests_sent  = 0;
    int  mismatch_count = 0;
    int  data_seen      = 0;
    int  reports_seen[5];
    int  quiet_cycles   = 0;
    int  ready_hold     = 0;
    int  phase_end;
    bit  idling_en      = 1'b1;
    ncfr_pkg::t_result got_want;

    // reflected crc-8, data folded in up front
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc ^ v;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ ncfr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic ncfr_pkg::t_result make_report(input ncfr_pkg::t_status st,
                                                      input logic [6:0] len,
                                                      input logic [7:0] cr,
                                                      input logic [7:0] cc);
        ncfr_pkg::t_result r;
        r = '0;
        r.is_end = 1'b1;
        r.status = st;
        r.payload_length = len;
        r.crc_received = cr;
        r.crc_computed = cc;
        return r;
    endfunction

    function automatic void post_report(input ncfr_pkg::t_status st, input logic [6:0] len,
                                        input logic [7:0] cr, input logic [7:0] cc);
        frame_out_q.push_back(make_report(st, len, cr, cc));
    endfunction

    function automatic void end_run();
        frame_open  = 1'b0;
        nibble_half = 1'b0;
        held_nib    = 4'd0;
        last_valid  = 1'b0;
        last_byte   = 8'd0;
        crc_acc     = 8'd0;
        raw_count   = 8'd0;
        byte_count  = 7'd0;
        tick_count  = 32'd0;
    endfunction

    // a new decoded byte releases the one held back before it
    function automatic void take_byte(input logic [7:0] v);
        ncfr_pkg::t_result r;
        if (last_valid) begin
            r = '0;
            r.status = ncfr_pkg::ST_OK;
            r.data_byte = last_byte;
            frame_out_q.push_back(r);
            crc_acc = crc8_fold(crc_acc, last_byte);
        end
        last_byte  = v;
        last_valid = 1'b1;
        byte_count = byte_count + 7'd1;
    endfunction

    function automatic void apply_cfg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            ncfr_pkg::CFG_START_CODE:    cfg_start = val[7:0];
            ncfr_pkg::CFG_END_CODE:      cfg_end = val[7:0];
            ncfr_pkg::CFG_TIMEOUT_TICKS: cfg_timeout = val;
            default: ;
        endcase
    endfunction

    function automatic void decode_request(input logic f, input logic [7:0] b);
        // millisecond tick
        if (f) begin
            if (tick_count != 32'hFFFF_FFFF) tick_count = tick_count + 32'd1;
            if (tick_count >= cfg_timeout) begin
                post_report(ncfr_pkg::ST_TIMEOUT, 7'd0, 8'd0, 8'd0);
                end_run();
            end
            return;
        end
        // byte arriving after the time limit is dropped
        if (tick_count >= cfg_timeout) begin
            post_report(ncfr_pkg::ST_TIMEOUT, 7'd0, 8'd0, 8'd0);
            end_run();
            return;
        end
        if (raw_count >= ncfr_pkg::RAW_CAPACITY) begin
            post_report(ncfr_pkg::ST_OVERFLOW, 7'd0, 8'd0, 8'd0);
            end_run();
            return;
        end
        if (b == cfg_start) begin
            end_run();
            frame_open = 1'b1;
            raw_count  = 8'd1;
            return;
        end
        if (b == cfg_end) begin
            // odd nibble count borrows the end byte's high half
            if (frame_open && nibble_half) take_byte({held_nib, cfg_end[7:4]});
            if (!frame_open || byte_count == 7'd0 || !last_valid) begin
                post_report(ncfr_pkg::ST_FRAME_ERR, 7'd0, 8'd0, 8'd0);
            end else begin
                post_report((last_byte == crc_acc) ? ncfr_pkg::ST_OK : ncfr_pkg::ST_BAD_CRC,
                            byte_count - 7'd1, last_byte, crc_acc);
            end
            end_run();
            return;
        end
        // code byte: nibble over its complement
        if (frame_open && (b[7:4] == ~b[3:0])) begin
            raw_count = raw_count + 8'd1;
            if (!nibble_half) begin
                held_nib    = b[7:4];
                nibble_half = 1'b1;
            end else begin
                nibble_half = 1'b0;
                take_byte({held_nib, b[7:4]});
            end
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    // stimulus table builders
    function automatic void row_item(input logic f, input logic [7:0] b);
        t_stim_row r;
        r = '0;
        r.func = f;
        r.rx_byte = b;
        stim_rows.push_back(r);
    endfunction

    function automatic void row_pin(input logic f, input logic [7:0] b,
                                    input ncfr_pkg::t_status st,
                                    input logic [6:0] len, input logic [7:0] cr,
                                    input logic [7:0] cc);
        t_stim_row r;
        r = '0;
        r.func = f;
        r.rx_byte = b;
        r.pinned = 1'b1;
        r.want = make_report(st, len, cr, cc);
        stim_rows.push_back(r);
    endfunction

    function automatic void row_cfg(input logic [1:0] idx, input logic [31:0] val);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_index = idx;
        r.cfg_value = val;
        stim_rows.push_back(r);
    endfunction

    // one request through the input handshake, with an optional gap first
    task automatic send_request(input logic f, input logic [7:0] b);
        int gap;
        if (idling_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= f;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_request(f, b);
        requests_sent++;
    endtask

    // stop sending and let every outstanding result come out
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (frame_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        apply_cfg(idx, val);
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1) == 1) send_request(1'b1, rand_byte());
        else send_request(1'b0, rand_byte());
    endtask

    // start, payload plus crc as code bytes, end; sometimes broken
    task automatic send_frame();
        logic [7:0] crc;
        logic [7:0] cur;
        logic [3:0] nib;
        int len;
        int nib_total;
        frame_bytes.delete();
        crc = 8'd0;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
            cur = rand_byte();
            frame_bytes.push_back(cur);
            crc = crc8_fold(crc, cur);
        end
        frame_bytes.push_back(($urandom_range(0, 3) != 0) ? crc : rand_byte());
        send_request(1'b0, cfg_start);
        nib_total = 2 * frame_bytes.size();
        if ($urandom_range(0, 5) == 0) nib_total--;
        for (int k = 0; k < nib_total; k++) begin
            cur = frame_bytes[k / 2];
            nib = k[0] ? cur[3:0] : cur[7:4];
            if ($urandom_range(0, 15) == 0) send_noise();
            send_request(1'b0, {nib, ~nib});
        end
        if ($urandom_range(0, 7) != 0) send_request(1'b0, cfg_end);
    endtask

    task automatic pick_config();
        logic [7:0]  code;
        logic [31:0] limit;
        for (int j = 0; j < 2; j++) begin
            case ($urandom_range(0, 5))
                0: code = 8'h00;
                1: code = 8'hFF;
                2: code = rand_byte();
                default: code = (j == 0) ? ncfr_pkg::START_CODE_RST
                                         : ncfr_pkg::END_CODE_RST;
            endcase
            cfg_write((j == 0) ? ncfr_pkg::CFG_START_CODE : ncfr_pkg::CFG_END_CODE,
                      {24'd0, code});
        end
        case ($urandom_range(0, 19))
            0: limit = 32'd0;
            1, 2, 3: limit = $urandom_range(1, 8);
            4, 5, 6, 7, 8: limit = $urandom_range(20, 300);
            9: limit = 32'hFFFF_FFFF;
            10: limit = $urandom;
            default: limit = ncfr_pkg::TIMEOUT_TICKS_RST;
        endcase
        cfg_write(ncfr_pkg::CFG_TIMEOUT_TICKS, limit);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random ready bursts
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            i_ready <= 1'b0;
        end else if (idling_en && $urandom_range(0, 6) == 0) begin
            ready_hold <= $urandom_range(0, 12);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest outstanding one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_out_q.size() == 0) begin
                $display("%0t: unexpected result, is_end %0h data %0h status %0h",
                         $time, o_is_end, o_data_byte, o_status);
                mismatch_count++;
            end else begin
                got_want = frame_out_q.pop_front();
                check_field("is_end", {7'd0, got_want.is_end}, {7'd0, o_is_end});
                check_field("data_byte", got_want.data_byte, o_data_byte);
                check_field("status", {5'd0, got_want.status}, {5'd0, o_status});
                check_field("payload_length", {1'b0, got_want.payload_length},
                            {1'b0, o_payload_length});
                check_field("crc_received", got_want.crc_received, o_crc_received);
                check_field("crc_computed", got_want.crc_computed, o_crc_computed);
                if (got_want.is_end) reports_seen[got_want.status]++;
                else data_seen++;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < 5; s++) reports_seen[s] = 0;
        cfg_start   = ncfr_pkg::START_CODE_RST;
        cfg_end     = ncfr_pkg::END_CODE_RST;
        cfg_timeout = ncfr_pkg::TIMEOUT_TICKS_RST;
        end_run();

        // directed table, reset configuration first
        row_pin(1'b0, 8'h03, ncfr_pkg::ST_FRAME_ERR, 7'd0, 8'd0, 8'd0);  // end, no frame
        row_item(1'b0, 8'hF0);                              // code byte outside a frame
        row_item(1'b1, 8'hFF);                              // tick
        row_item(1'b0, 8'h02);
        row_pin(1'b0, 8'h03, ncfr_pkg::ST_FRAME_ERR, 7'd0, 8'd0, 8'd0);  // nothing decoded
        row_item(1'b0, 8'h02);
        row_item(1'b0, 8'h0F);
        row_item(1'b0, 8'h0F);
        row_pin(1'b0, 8'h03, ncfr_pkg::ST_OK, 7'd0, 8'd0, 8'd0);  // crc byte only, zero
        // payload ff 58, stray byte, odd nibble closed by end byte
        row_item(1'b0, 8'h02);
        row_item(1'b0, 8'hF0);
        row_item(1'b0, 8'hF0);
        row_item(1'b0, 8'h5A);
        row_item(1'b0, 8'h55);
        row_item(1'b0, 8'h87);
        row_item(1'b0, 8'h3C);
        row_item(1'b0, 8'h03);
        // tick limit reached
        row_cfg(ncfr_pkg::CFG_TIMEOUT_TICKS, 32'd2);
        row_item(1'b1, 8'h00);
        row_pin(1'b1, 8'h00, ncfr_pkg::ST_TIMEOUT, 7'd0, 8'd0, 8'd0);
        // zero limit drops the byte
        row_cfg(ncfr_pkg::CFG_TIMEOUT_TICKS, 32'd0);
        row_pin(1'b0, 8'hA5, ncfr_pkg::ST_TIMEOUT, 7'd0, 8'd0, 8'd0);
        // extreme codes
        row_cfg(ncfr_pkg::CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        row_cfg(ncfr_pkg::CFG_START_CODE, 32'h0000_0000);
        row_cfg(ncfr_pkg::CFG_END_CODE, 32'h0000_00FF);
        row_item(1'b0, 8'h00);
        row_item(1'b0, 8'h0F);
        row_item(1'b0, 8'hF0);
        row_item(1'b0, 8'h3C);
        row_item(1'b0, 8'hFF);
        // start and end share a code byte value: start wins
        row_cfg(ncfr_pkg::CFG_START_CODE, 32'h0000_00A5);
        row_cfg(ncfr_pkg::CFG_END_CODE, 32'h0000_00A5);
        row_item(1'b0, 8'hA5);
        row_item(1'b0, 8'hA5);
        row_cfg(CFG_UNUSED, 32'hDEAD_BEEF);

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[n]) begin
            row = stim_rows[n];
            if (row.is_cfg) begin
                wait_results_done();
                cfg_write(row.cfg_index, row.cfg_value);
            end else begin
                send_request(row.func, row.rx_byte);
                if (row.pinned) frame_out_q[$] = row.want;
            end
        end

        // random phases, each with its own configuration
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_results_done();
            pick_config();
            idling_en = (ph == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            phase_end = requests_sent + RAND_REQUESTS / RAND_PHASES;
            while (requests_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0) send_noise();
                else send_frame();
            end
        end

        wait_results_done();
        repeat (END_TAIL) @(posedge i_clk);
        if (frame_out_q.size() != 0) begin
            $display("%0t: results missing, expected %0d more actual 0",
                     $time, frame_out_q.size());
            mismatch_count++;
        end

        $display("%0d requests sent, %0d payload bytes checked, %0d mismatches",
                 requests_sent, data_seen, mismatch_count);
        $display("frame reports: ok %0d, bad crc %0d, overflow %0d, timeout %0d, framing %0d",
                 reports_seen[ncfr_pkg::ST_OK], reports_seen[ncfr_pkg::ST_BAD_CRC],
                 reports_seen[ncfr_pkg::ST_OVERFLOW], reports_seen[ncfr_pkg::ST_TIMEOUT],
                 reports_seen[ncfr_pkg::ST_FRAME_ERR]);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
